// ===== hdl/pqcs_pkg.sv =====
package pqcs_pkg;

    localparam int MAX_POINT_COUNT_DEF = 32;
    localparam int COORD_WIDTH_DEF     = 32;
    localparam int LOC_W               = 3;
    localparam int IDX_W               = 6;
    localparam int QUEUE_DEPTH         = 2;

    typedef enum logic [LOC_W-1:0] {
        LOC_Q1     = 3'd0,
        LOC_Q2     = 3'd1,
        LOC_Q3     = 3'd2,
        LOC_Q4     = 3'd3,
        LOC_XAXIS  = 3'd4,
        LOC_YAXIS  = 3'd5,
        LOC_ORIGIN = 3'd6
    } loc_t;

    // control part of one classified point on its way to the back end
    typedef struct packed {
        logic keep;      // point has a store slot
        logic last;      // point closes the set
        logic dropped;   // some point of this run found the store full
        loc_t code;
    } pqcs_ctl_t;

    localparam int CTL_W = $bits(pqcs_ctl_t);

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_READ,
        BK_CHECK
    } back_state_t;

endpackage

// ===== hdl/pqcs_front.sv =====
module pqcs_front
    import pqcs_pkg::*;
#(
    parameter int MAX_POINT_COUNT = MAX_POINT_COUNT_DEF,
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    localparam int ADDR_W = (MAX_POINT_COUNT > 1) ? $clog2(MAX_POINT_COUNT) : 1,
    localparam int CNT_W  = $clog2(MAX_POINT_COUNT + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COORD_WIDTH-1:0] x_coord,
    input  logic [COORD_WIDTH-1:0] y_coord,
    input  logic                   final_point,
    input  logic                   push,
    input  logic                   q_full,
    output logic                   q_push,
    output pqcs_ctl_t              q_ctl,
    output logic [ADDR_W-1:0]      q_idx
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             has_room;
    logic             x_neg, y_neg, x_zero, y_zero;
    loc_t             code;

    assign x_neg  = x_coord[COORD_WIDTH-1];
    assign y_neg  = y_coord[COORD_WIDTH-1];
    assign x_zero = (x_coord == '0);
    assign y_zero = (y_coord == '0);

    always_comb
    begin
        priority if (x_zero && y_zero)
            code = LOC_ORIGIN;
        else if (x_zero)
            code = LOC_YAXIS;
        else if (y_zero)
            code = LOC_XAXIS;
        else if (!y_neg)
            code = x_neg ? LOC_Q2 : LOC_Q1;
        else
            code = x_neg ? LOC_Q3 : LOC_Q4;
    end

    assign has_room = (count_reg < CNT_W'(MAX_POINT_COUNT));
    assign q_push   = push && !q_full;

    assign q_ctl.keep    = has_room;
    assign q_ctl.last    = final_point;
    assign q_ctl.dropped = ovf_reg || !has_room;
    assign q_ctl.code    = code;
    assign q_idx         = count_reg[ADDR_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (q_push)
        begin
            if (final_point)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (has_room)
                count_next = count_reg + CNT_W'(1);
            else
                ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== hdl/pqcs_fifo.sv =====
module pqcs_fifo
    import pqcs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/pqcs_back.sv =====
module pqcs_back
    import pqcs_pkg::*;
#(
    parameter int MAX_POINT_COUNT = MAX_POINT_COUNT_DEF,
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    localparam int ADDR_W = (MAX_POINT_COUNT > 1) ? $clog2(MAX_POINT_COUNT) : 1,
    localparam int CNT_W  = $clog2(MAX_POINT_COUNT + 1),
    localparam int ENT_W  = 2 * COORD_WIDTH + LOC_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  pqcs_ctl_t              q_ctl,
    input  logic [ADDR_W-1:0]      q_idx,
    input  logic [COORD_WIDTH-1:0] q_x,
    input  logic [COORD_WIDTH-1:0] q_y,
    output logic [IDX_W-1:0]       point_index,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic [LOC_W-1:0]       location_code,
    output logic                   run_last,
    output logic                   points_dropped,
    output logic                   empty,
    input  logic                   pop
);

    logic [ENT_W-1:0]       mem [MAX_POINT_COUNT];
    logic [ENT_W-1:0]       rd_data_reg;

    back_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    loc_t                   max_code_reg, max_code_next;
    logic [ADDR_W-1:0]      last_idx_reg, last_idx_next;
    logic                   drop_reg, drop_next;
    loc_t                   scan_code_reg, scan_code_next;
    logic [ADDR_W-1:0]      scan_idx_reg, scan_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       out_idx_reg;
    logic [COORD_WIDTH-1:0] out_x_reg, out_y_reg;
    loc_t                   out_code_reg;
    logic                   out_last_reg, out_drop_reg;

    logic                   take, wr_en, rd_en, load_out;
    logic                   code_match, is_last, out_free, row_end;
    loc_t                   rd_code;
    logic [COORD_WIDTH-1:0] rd_x, rd_y;

    assign take  = (state_reg == BK_LOAD) && !q_empty;
    assign wr_en = take && q_ctl.keep;

    assign rd_code = loc_t'(rd_data_reg[LOC_W-1:0]);
    assign rd_y    = rd_data_reg[LOC_W +: COORD_WIDTH];
    assign rd_x    = rd_data_reg[LOC_W + COORD_WIDTH +: COORD_WIDTH];

    assign code_match = (rd_code == scan_code_reg);
    // the last result is the newest entry holding the highest code of the run
    assign is_last    = (scan_code_reg == max_code_reg) && (scan_idx_reg == last_idx_reg);
    assign out_free   = !out_valid_reg || pop;
    assign row_end    = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOAD:
                if (take && q_ctl.last)
                    state_next = BK_READ;
            BK_READ:
                state_next = BK_CHECK;
            BK_CHECK:
                if (!code_match || out_free)
                    state_next = is_last ? BK_LOAD : BK_READ;
            default:
                state_next = BK_LOAD;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_LOAD:  q_pop    = take;
            BK_READ:  rd_en    = 1'b1;
            BK_CHECK: load_out = code_match && out_free;
            default:  q_pop    = 1'b0;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        max_code_next  = max_code_reg;
        last_idx_next  = last_idx_reg;
        drop_next      = drop_reg;
        scan_code_next = scan_code_reg;
        scan_idx_next  = scan_idx_reg;
        if (wr_en)
        begin
            count_next = CNT_W'(q_idx) + CNT_W'(1);
            if (q_idx == '0 || q_ctl.code >= max_code_reg)
            begin
                max_code_next = q_ctl.code;
                last_idx_next = q_idx;
            end
        end
        if (take && q_ctl.last)
        begin
            drop_next      = q_ctl.dropped;
            scan_code_next = LOC_Q1;
            scan_idx_next  = '0;
        end
        if (state_reg == BK_CHECK && (!code_match || out_free) && !is_last)
        begin
            if (row_end)
            begin
                scan_idx_next  = '0;
                scan_code_next = loc_t'(scan_code_reg + LOC_W'(1));
            end
            else
                scan_idx_next = scan_idx_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_LOAD;
            count_reg     <= '0;
            max_code_reg  <= LOC_Q1;
            last_idx_reg  <= '0;
            drop_reg      <= 1'b0;
            scan_code_reg <= LOC_Q1;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_code_reg  <= max_code_next;
            last_idx_reg  <= last_idx_next;
            drop_reg      <= drop_next;
            scan_code_reg <= scan_code_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[q_idx] <= {q_x, q_y, q_ctl.code};
        if (rd_en)
            rd_data_reg <= mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_idx_reg  <= IDX_W'(scan_idx_reg);
            out_x_reg    <= rd_x;
            out_y_reg    <= rd_y;
            out_code_reg <= rd_code;
            out_last_reg <= is_last;
            out_drop_reg <= drop_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign point_index    = out_idx_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign location_code  = out_code_reg;
    assign run_last       = out_last_reg;
    assign points_dropped = out_drop_reg;

endmodule

// ===== hdl/point_quadrant_classify_sort_top.sv =====
// Points enter one per cycle while full is low; each is classified into a location code
// (quadrants Q1..Q4 as 0..3, x-axis 4, y-axis 5, origin 6), given its arrival index and
// passed through a two-entry queue into a MAX_POINT_COUNT-entry store. The point marked
// final_point starts the sorted run: the back end walks the store once per code, 0 to 6,
// reading one entry per pass through BK_READ and BK_CHECK via the single registered read
// port of the store, and stops at the last result. During the run the queue is not
// drained, so once it fills full stays high. Points beyond the store's capacity are
// dropped and every result of that run shows points_dropped. The result register lets
// the next result be prepared while one waits.
module point_quadrant_classify_sort_top
    import pqcs_pkg::*;
#(
    parameter int MAX_POINT_COUNT = MAX_POINT_COUNT_DEF,
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COORD_WIDTH-1:0] x_coord,
    input  logic [COORD_WIDTH-1:0] y_coord,
    input  logic                   final_point,
    input  logic                   push,
    output logic                   full,
    output logic [IDX_W-1:0]       point_index,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic [LOC_W-1:0]       location_code,
    output logic                   run_last,
    output logic                   points_dropped,
    output logic                   empty,
    input  logic                   pop
);

    localparam int ADDR_W = (MAX_POINT_COUNT > 1) ? $clog2(MAX_POINT_COUNT) : 1;
    localparam int ITEM_W = 2 * COORD_WIDTH + ADDR_W + CTL_W;

    logic                   f_push, q_full, q_empty, q_pop;
    pqcs_ctl_t              f_ctl, b_ctl;
    logic [ADDR_W-1:0]      f_idx, b_idx;
    logic [COORD_WIDTH-1:0] b_x, b_y;
    logic [ITEM_W-1:0]      q_rd_data;

    pqcs_front #(
        .MAX_POINT_COUNT(MAX_POINT_COUNT),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .final_point(final_point),
        .push       (push),
        .q_full     (q_full),
        .q_push     (f_push),
        .q_ctl      (f_ctl),
        .q_idx      (f_idx)
    );

    pqcs_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (f_push),
        .wr_data({x_coord, y_coord, f_idx, f_ctl}),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(q_rd_data),
        .empty  (q_empty)
    );

    assign b_ctl = pqcs_ctl_t'(q_rd_data[CTL_W-1:0]);
    assign b_idx = q_rd_data[CTL_W +: ADDR_W];
    assign b_y   = q_rd_data[CTL_W + ADDR_W +: COORD_WIDTH];
    assign b_x   = q_rd_data[CTL_W + ADDR_W + COORD_WIDTH +: COORD_WIDTH];

    pqcs_back #(
        .MAX_POINT_COUNT(MAX_POINT_COUNT),
        .COORD_WIDTH    (COORD_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_ctl         (b_ctl),
        .q_idx         (b_idx),
        .q_x           (b_x),
        .q_y           (b_y),
        .point_index   (point_index),
        .out_x         (out_x),
        .out_y         (out_y),
        .location_code (location_code),
        .run_last      (run_last),
        .points_dropped(points_dropped),
        .empty         (empty),
        .pop           (pop)
    );

    assign full = q_full;

endmodule

// ===== hdl/pqcs_checker.sv =====
module pqcs_checker
    import pqcs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic [IDX_W-1:0]       point_index,
    input logic [COORD_WIDTH-1:0] out_x,
    input logic [COORD_WIDTH-1:0] out_y,
    input logic [LOC_W-1:0]       location_code,
    input logic                   run_last,
    input logic                   points_dropped,
    input logic                   empty,
    input logic                   pop
);

    logic             xfer;
    logic             in_run_reg;
    logic [LOC_W-1:0] prev_code_reg;
    logic             prev_drop_reg;

    assign xfer = pop && !empty;

    // tracks whether the previous transfer left a run open
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg    <= 1'b0;
            prev_code_reg <= '0;
            prev_drop_reg <= 1'b0;
        end
        else if (xfer)
        begin
            in_run_reg    <= !run_last;
            prev_code_reg <= location_code;
            prev_drop_reg <= points_dropped;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(point_index) && $stable(out_x)
            && $stable(out_y) && $stable(location_code) && $stable(run_last))
        else $error("waiting result changed");

    a_codes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && in_run_reg |-> location_code >= prev_code_reg)
        else $error("location codes out of order within a run");

    a_drop_constant: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && in_run_reg |-> points_dropped == prev_drop_reg)
        else $error("points_dropped changed within a run");

    a_code_matches_point: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (location_code == LOC_ORIGIN) == (out_x == '0 && out_y == '0))
        else $error("origin code does not match coordinates");

endmodule

bind point_quadrant_classify_sort_top pqcs_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_pqcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .point_index   (point_index),
    .out_x         (out_x),
    .out_y         (out_y),
    .location_code (location_code),
    .run_last      (run_last),
    .points_dropped(points_dropped),
    .empty         (empty),
    .pop           (pop)
);
